FILE: hdl/gms_pkg.sv
// ----------------------------------------------------------------------------
// gms_pkg
// Shared types, register indexes and the control program of the gap merge
// sequencer.
// ----------------------------------------------------------------------------
package gms_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 7;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_LEN  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SECOND_LEN = 8'd1;

    // value word
    localparam int VALUE_W = 32;

    // step counter
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_LOAD    = 4'd0;
    localparam step_t STEP_MINIT   = 4'd1;
    localparam step_t STEP_PTEST   = 4'd2;
    localparam step_t STEP_RDPAIR  = 4'd3;
    localparam step_t STEP_CMP     = 4'd4;
    localparam step_t STEP_WRHI    = 4'd5;
    localparam step_t STEP_GAPNEXT = 4'd6;
    localparam step_t STEP_ORD     = 4'd7;
    localparam step_t STEP_OLD     = 4'd8;
    localparam step_t STEP_FIN     = 4'd9;

    // datapath operation of one step
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MINIT,
        OP_TEST,
        OP_READ_PAIR,
        OP_SWAP_LO,
        OP_WRHI,
        OP_GAP,
        OP_READ_OUT,
        OP_EMIT
    } op_t;

    // sequencing condition of one step
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_JUMP,
        COND_LOAD,
        COND_PASS_END,
        COND_NO_SWAP,
        COND_GAP_MORE,
        COND_OUT
    } cond_t;

    // control word
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucw_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic in_acc;
        logic full;
        logic pass_end;
        logic swap;
        logic gap_one;
        logic out_free;
        logic out_last;
    } status_t;

    // control program
    function automatic ucw_t ucode(input step_t step);
        ucw_t w;
        w = '{op: OP_NONE, cond: COND_JUMP, target: STEP_LOAD};
        unique case (step)
            STEP_LOAD:    w = '{op: OP_LOAD,      cond: COND_LOAD,     target: STEP_LOAD};
            STEP_MINIT:   w = '{op: OP_MINIT,     cond: COND_NEXT,     target: STEP_LOAD};
            STEP_PTEST:   w = '{op: OP_TEST,      cond: COND_PASS_END, target: STEP_GAPNEXT};
            STEP_RDPAIR:  w = '{op: OP_READ_PAIR, cond: COND_NEXT,     target: STEP_LOAD};
            STEP_CMP:     w = '{op: OP_SWAP_LO,   cond: COND_NO_SWAP,  target: STEP_PTEST};
            STEP_WRHI:    w = '{op: OP_WRHI,      cond: COND_JUMP,     target: STEP_PTEST};
            STEP_GAPNEXT: w = '{op: OP_GAP,       cond: COND_GAP_MORE, target: STEP_PTEST};
            STEP_ORD:     w = '{op: OP_READ_OUT,  cond: COND_NEXT,     target: STEP_LOAD};
            STEP_OLD:     w = '{op: OP_EMIT,      cond: COND_OUT,      target: STEP_ORD};
            STEP_FIN:     w = '{op: OP_NONE,      cond: COND_JUMP,     target: STEP_LOAD};
            default:      w = '{op: OP_NONE,      cond: COND_JUMP,     target: STEP_LOAD};
        endcase
        return w;
    endfunction

endpackage

FILE: hdl/gms_ram.sv
// ----------------------------------------------------------------------------
// gms_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module gms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read ports
    always_ff @(posedge aclk) begin
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

FILE: hdl/gms_seq.sv
// ----------------------------------------------------------------------------
// gms_seq
// Step counter and control program: fetches one control word per step and
// picks the next step from its condition and the datapath status.
// ----------------------------------------------------------------------------
module gms_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  gms_pkg::status_t status,
    output gms_pkg::ucw_t    ucw
);

    import gms_pkg::*;

    step_t step_reg;
    step_t step_next;

    // control word fetch
    assign ucw = ucode(step_reg);

    // next step
    always_comb begin
        step_next = step_reg + 4'd1;
        unique case (ucw.cond)
            COND_NEXT: begin
                step_next = step_reg + 4'd1;
            end
            COND_JUMP: begin
                step_next = ucw.target;
            end
            COND_LOAD: begin
                if (!status.in_acc) begin
                    step_next = step_reg;
                end else if (!status.full) begin
                    step_next = ucw.target;
                end
            end
            COND_PASS_END: begin
                if (status.pass_end) begin
                    step_next = ucw.target;
                end
            end
            COND_NO_SWAP: begin
                if (!status.swap) begin
                    step_next = ucw.target;
                end
            end
            COND_GAP_MORE: begin
                if (!status.gap_one) begin
                    step_next = ucw.target;
                end
            end
            COND_OUT: begin
                if (!status.out_free) begin
                    step_next = step_reg;
                end else if (!status.out_last) begin
                    step_next = ucw.target;
                end
            end
            default: begin
                step_next = STEP_LOAD;
            end
        endcase
    end

    // step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_LOAD;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

FILE: hdl/gap_merge_sorted_arrays.sv
// ----------------------------------------------------------------------------
// gap_merge_sorted_arrays
// Loads two sorted runs into one store, merges them in place with the gap
// method and streams the merged values out in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   Write first_len (index 0) and second_len (index 1) on the cfg channel
//   while the block is idle; cfg_ready is always high. Their sum, clipped to
//   MAX_TOTAL, is the run total; a zero total makes every value a no-op.
//   Values enter on s_ one per cycle while the block loads. The value that
//   completes the total starts the merge; s_tready stays low until the last
//   merged value has been handed to the output register.
//   The merge runs one setup step, per gap pass two steps (closing test and
//   gap update) plus per compare a test, a pair read and a compare, with a
//   write of the upper slot added when the pair swaps since the store has a
//   single write port. For 64 values that is 321 compares.
//   Results then leave on m_, each value through a store read and then an
//   output register load; m_tlast marks the final value, m_tuser says
//   the position lies in the second run's part.
//   A stalled receiver holds the output register and the sequencer waits;
//   the next load may start while the final value is still unaccepted.
//   Reset clears the step counter, counters, lengths and output valid; the
//   store is not cleared since every entry is written before it is read.
// ----------------------------------------------------------------------------
module gap_merge_sorted_arrays #(
    parameter int MAX_TOTAL = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gms_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gms_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input values
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gms_pkg::VALUE_W-1:0]     s_tdata,   // [31:0] value
    // merged values
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gms_pkg::VALUE_W-1:0]     m_tdata,   // [31:0] merged_value
    output logic                            m_tuser,   // [0] in_second
    output logic                            m_tlast
);

    import gms_pkg::*;

    localparam int AW = $clog2(MAX_TOTAL);
    localparam int CW = $clog2(MAX_TOTAL + 1);

    ucw_t    ucw;
    status_t status;

    logic [CFG_DATA_W-1:0] first_len_reg;
    logic [CFG_DATA_W-1:0] second_len_reg;

    logic [CW-1:0] load_count_reg;
    logic [CW-1:0] gap_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] out_idx_reg;
    logic [VALUE_W-1:0] lo_val_reg;

    logic               m_valid_reg;
    logic [VALUE_W-1:0] m_data_reg;
    logic               m_user_reg;
    logic               m_last_reg;

    logic [CFG_DATA_W:0] len_sum;
    logic [CW-1:0]       total;
    logic [CW-1:0]       first_part;
    logic [CW:0]         hi_sum;
    logic [CW:0]         gap_half;
    logic [CW:0]         total_half;
    logic                in_acc;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr0;
    logic [VALUE_W-1:0] ram_rdata0;
    logic [VALUE_W-1:0] ram_rdata1;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_len_reg  <= '0;
            second_len_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_FIRST_LEN) begin
                first_len_reg <= cfg_data;
            end else if (cfg_index == REG_SECOND_LEN) begin
                second_len_reg <= cfg_data;
            end
        end
    end

    // clipped total and first part
    assign len_sum = {1'b0, first_len_reg} + {1'b0, second_len_reg};
    assign total   = (len_sum > (CFG_DATA_W + 1)'(MAX_TOTAL)) ? CW'(MAX_TOTAL)
                                                              : len_sum[CW-1:0];
    assign first_part = ({1'b0, first_len_reg} < (CFG_DATA_W + 1)'(total))
                        ? first_len_reg[CW-1:0] : total;

    // derived values
    assign hi_sum     = {1'b0, idx_reg} + {1'b0, gap_reg};
    assign gap_half   = ({1'b0, gap_reg} + 1'b1) >> 1;
    assign total_half = ({1'b0, total} + 1'b1) >> 1;

    assign s_tready = (ucw.op == OP_LOAD);
    assign in_acc   = s_tvalid && s_tready;

    // status to the sequencer
    always_comb begin
        status.in_acc   = in_acc;
        status.full     = (total != '0) &&
                          (({1'b0, load_count_reg} + 1'b1) >= {1'b0, total});
        status.pass_end = (hi_sum >= {1'b0, total});
        status.swap     = ($signed(ram_rdata0) > $signed(ram_rdata1));
        status.gap_one  = (gap_reg == CW'(1));
        status.out_free = !m_valid_reg || m_tready;
        status.out_last = (({1'b0, out_idx_reg} + 1'b1) == {1'b0, total});
    end

    gms_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ucw     (ucw)
    );

    // store write port
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[AW-1:0];
        ram_wdata = ram_rdata1;
        case (ucw.op)
            OP_LOAD: begin
                ram_we    = in_acc && (total != '0);
                ram_waddr = load_count_reg[AW-1:0];
                ram_wdata = s_tdata;
            end
            OP_SWAP_LO: begin
                ram_we    = status.swap;
                ram_waddr = idx_reg[AW-1:0];
                ram_wdata = ram_rdata1;
            end
            OP_WRHI: begin
                ram_we    = 1'b1;
                ram_waddr = hi_sum[AW-1:0];
                ram_wdata = lo_val_reg;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // store read addresses: pair while merging, output index while emitting
    assign ram_raddr0 = ((ucw.op == OP_READ_OUT) || (ucw.op == OP_EMIT))
                        ? out_idx_reg[AW-1:0] : idx_reg[AW-1:0];

    gms_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_TOTAL)
    ) u_store (
        .aclk   (aclk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr0 (ram_raddr0),
        .raddr1 (hi_sum[AW-1:0]),
        .rdata0 (ram_rdata0),
        .rdata1 (ram_rdata1)
    );

    // counters and merge indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_count_reg <= '0;
            gap_reg        <= '0;
            idx_reg        <= '0;
            out_idx_reg    <= '0;
        end else begin
            case (ucw.op)
                OP_LOAD: begin
                    if (in_acc) begin
                        if (total == '0) begin
                            load_count_reg <= '0;
                        end else begin
                            load_count_reg <= load_count_reg + 1'b1;
                        end
                    end
                end
                OP_MINIT: begin
                    load_count_reg <= '0;
                    gap_reg        <= total_half[CW-1:0];
                    idx_reg        <= '0;
                end
                OP_SWAP_LO: begin
                    if (!status.swap) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                OP_WRHI: begin
                    idx_reg <= idx_reg + 1'b1;
                end
                OP_GAP: begin
                    out_idx_reg <= '0;
                    idx_reg     <= '0;
                    if (status.gap_one) begin
                        gap_reg <= '0;
                    end else begin
                        gap_reg <= gap_half[CW-1:0];
                    end
                end
                OP_EMIT: begin
                    if (status.out_free) begin
                        out_idx_reg <= out_idx_reg + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // value of the lower slot of the pair, written to the upper slot on a swap
    always_ff @(posedge aclk) begin
        if (ucw.op == OP_SWAP_LO) begin
            lo_val_reg <= ram_rdata0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((ucw.op == OP_EMIT) && status.out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((ucw.op == OP_EMIT) && status.out_free) begin
            m_data_reg <= ram_rdata0;
            m_user_reg <= (out_idx_reg >= first_part);
            m_last_reg <= status.out_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    // a pair read always lies inside the run
    a_pair_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (ucw.op == OP_READ_PAIR) |-> (hi_sum < {1'b0, total}))
        else $error("pair read beyond run total");

    // the gap is never zero while a pass runs
    a_gap_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (ucw.op == OP_TEST) |-> (gap_reg != '0))
        else $error("zero gap during merge pass");

    // a held result stays put while the receiver stalls
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)
                                     && $stable(m_tuser) && $stable(m_tlast)))
        else $error("output changed while stalled");

    // no input is taken while the sequencer merges or emits
    a_no_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ((ucw.op == OP_SWAP_LO) || (ucw.op == OP_EMIT)) |-> !s_tready)
        else $error("input ready outside load step");
`endif

endmodule

FILE: tb/tb_gap_merge_sorted_arrays.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gap_merge_sorted_arrays
// Streams pairs of runs, mostly sorted, into the merger and keeps its own
// gap merge of the same store. Every merged value is checked in order against
// that prediction, together with its second-part flag and the end-of-burst
// marker. Both stream sides idle at random, and the receiver once holds
// off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_gap_merge_sorted_arrays;
    import gms_pkg::*;

    localparam int MAX_TOTAL       = 64;
    localparam int ITEM_TARGET     = 400;
    localparam int MAX_IDLE        = 16;
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_OFF_CYCLES = 2000;
    localparam int CYCLE_LIMIT     = 400000;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef struct packed {
        value_t merged_value;
        logic   in_second;
        logic   last;
    } merged_t;

    // predicted store contents and the merged bursts still owed by the block
    class merge_tracker;
        value_t      value_store [MAX_TOTAL];
        int unsigned fill_count;
        int unsigned first_len;
        int unsigned second_len;
        merged_t     merged_q [$];
        int unsigned fail_count;

        function void write_length(input logic [CFG_INDEX_W-1:0] index,
                                   input logic [CFG_DATA_W-1:0] data);
            if (index == REG_FIRST_LEN) begin
                first_len = 32'(data);
            end else if (index == REG_SECOND_LEN) begin
                second_len = 32'(data);
            end
        endfunction

        function void report(input string what);
            fail_count++;
            if (fail_count <= 10) begin
                $display("%s", what);
            end
        endfunction

        function void note_value(input value_t value);
            int unsigned total;
            int unsigned first_part;
            int unsigned gap;
            int unsigned i;
            value_t      held;
            merged_t     item;
            total = first_len + second_len;
            if (total > MAX_TOTAL) begin
                total = MAX_TOTAL;
            end
            first_part = (first_len < total) ? first_len : total;
            // zero total drops the value and restarts loading
            if (total == 0) begin
                fill_count = 0;
                return;
            end
            if (fill_count < MAX_TOTAL) begin
                value_store[fill_count] = value;
            end
            fill_count++;
            if (fill_count < total) begin
                return;
            end
            // gap passes, halving with round-up, ending after the gap-one pass
            gap = (total + 1) / 2;
            while (gap > 0) begin
                for (i = 0; i + gap < total; i++) begin
                    if (value_store[i] > value_store[i + gap]) begin
                        held                 = value_store[i];
                        value_store[i]       = value_store[i + gap];
                        value_store[i + gap] = held;
                    end
                end
                gap = (gap == 1) ? 0 : (gap + 1) / 2;
            end
            // burst in ascending order, flagged by part and end
            for (i = 0; i < total; i++) begin
                item.merged_value = value_store[i];
                item.in_second    = (i >= first_part);
                item.last         = (i + 1 == total);
                merged_q.push_back(item);
            end
            fill_count = 0;
        endfunction

        function void check_result(input merged_t got);
            merged_t want;
            if (merged_q.size() == 0) begin
                report($sformatf("unexpected output: value %0d in_second %0b last %0b",
                                 got.merged_value, got.in_second, got.last));
                return;
            end
            want = merged_q.pop_front();
            if (got.merged_value !== want.merged_value || got.in_second !== want.in_second
                    || got.last !== want.last) begin
                report($sformatf({"mismatch: expected value %0d in_second %0b last %0b,",
                                  " got value %0d in_second %0b last %0b"},
                                 want.merged_value, want.in_second, want.last,
                                 got.merged_value, got.in_second, got.last));
            end
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_FIRST_LEN;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [VALUE_W-1:0]     s_tdata   = '0;    // [31:0] value
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [VALUE_W-1:0]     m_tdata;           // [31:0] merged_value
    logic                   m_tuser;           // [0] in_second
    logic                   m_tlast;

    // idling modes set by the stimulus; the rx_ ones steer the receiver
    bit tx_steady   = 1'b0;
    bit rx_steady   = 1'b0;
    bit rx_hold_req = 1'b0;

    int unsigned  cycle_count = 0;
    merge_tracker tracker     = new();

    gap_merge_sorted_arrays #(
        .MAX_TOTAL (MAX_TOTAL)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("gap_merge_sorted_arrays test failed");
            $finish;
        end
    end

    // write both lengths back to back, valid held high across the pair
    task automatic set_lengths(input int first_n, input int second_n);
        logic [CFG_INDEX_W-1:0] index_list [2];
        logic [CFG_DATA_W-1:0]  data_list [2];
        index_list[0] = REG_FIRST_LEN;
        index_list[1] = REG_SECOND_LEN;
        data_list[0]  = CFG_DATA_W'(first_n);
        data_list[1]  = CFG_DATA_W'(second_n);
        cfg_valid <= 1'b1;
        for (int k = 0; k < 2; k++) begin
            cfg_index <= index_list[k];
            cfg_data  <= data_list[k];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            tracker.write_length(index_list[k], data_list[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    // one value request, with a random gap ahead of it unless tx_steady is set
    task automatic send_value(input value_t value);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.note_value(value);
    endtask

    // wait until every predicted value has left, then let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (tracker.merged_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // value styles: full range, narrow with many repeats, extremes
    function automatic int draw_value(input int style);
        case (style)
            1: return $urandom_range(0, 8) - 4;
            2: begin
                case ($urandom_range(0, 3))
                    0: return int'(32'h8000_0000);
                    1: return int'(32'h7FFF_FFFF);
                    2: return 0;
                    default: return -1;
                endcase
            end
            default: return int'($urandom);
        endcase
    endfunction

    // two runs, each sorted unless asked otherwise; only count values are sent
    task automatic send_run(input int first_n, input int second_n, input bit ordered,
                            input int count);
        int run_a [$];
        int run_b [$];
        int style;
        style = $urandom_range(0, 3);
        repeat (first_n) run_a.push_back(draw_value(style));
        repeat (second_n) run_b.push_back(draw_value(style));
        if (ordered) begin
            run_a.sort();
            run_b.sort();
        end
        run_a = {run_a, run_b};
        for (int k = 0; k < count; k++) begin
            send_value(run_a[k]);
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin : receiver
        int      stall;
        merged_t got;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                stall = HOLD_OFF_CYCLES;
            end else if (rx_steady) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, MAX_IDLE);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            got.merged_value = m_tdata;
            got.in_second    = m_tuser;
            got.last         = m_tlast;
            tracker.check_result(got);
        end
    end

    initial begin : stimulus
        int f;
        int s;
        int fn;
        int total;
        int runs;
        int r;
        int count;
        int mode;
        int loaded;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single values at both extremes, one per part
        set_lengths(1, 0);
        send_value(32'h8000_0000);
        wait_idle();
        set_lengths(0, 1);
        send_value(32'h7FFF_FFFF);
        wait_idle();
        // one value per part, swapped by the gap-one pass
        set_lengths(1, 1);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        wait_idle();
        // equal values in both parts are not swapped against each other
        set_lengths(2, 2);
        send_value(-5);
        send_value(7);
        send_value(-5);
        send_value(3);
        wait_idle();
        // both lengths zero: values are dropped
        set_lengths(0, 0);
        send_value(11);
        send_value(-11);
        wait_idle();
        // total shrinks below the count already loaded
        set_lengths(3, 3);
        send_value(1);
        send_value(2);
        send_value(3);
        send_value(-1);
        wait_idle();
        set_lengths(3, 0);
        send_value(9);
        wait_idle();
        // total grows while loading
        set_lengths(2, 1);
        send_value(40);
        wait_idle();
        set_lengths(2, 2);
        send_value(50);
        send_value(-60);
        send_value(70);
        wait_idle();

        // receiver holds off while two runs are offered back to back
        set_lengths(20, 12);
        rx_hold_req = 1'b1;
        tx_steady   = 1'b1;
        send_run(20, 12, 1'b1, 32);
        send_run(20, 12, 1'b1, 32);
        tx_steady = 1'b0;
        wait_idle();
        loaded = 64;

        // random phases: mostly short sorted runs, a few full-size, oversized or empty
        while (loaded < ITEM_TARGET) begin
            case ($urandom_range(0, 31))
                0: begin f = 64; s = 64; end
                1: begin f = 64; s = 0; end
                2: begin f = 0; s = 64; end
                3: begin f = 63; s = 1; end
                4: begin f = $urandom_range(0, 64); s = $urandom_range(0, 64); end
                5, 6: begin f = 0; s = 0; end
                default: begin f = $urandom_range(0, 6); s = $urandom_range(0, 6); end
            endcase
            set_lengths(f, s);
            total     = (f + s > MAX_TOTAL) ? MAX_TOTAL : f + s;
            fn        = (f < total) ? f : total;
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            if (total == 0) begin
                repeat ($urandom_range(1, 3)) send_value(draw_value(0));
            end else begin
                runs = $urandom_range(1, 3);
                for (r = 0; r < runs; r++) begin
                    // mostly sorted runs, some unsorted, some cut short
                    mode  = $urandom_range(0, 9);
                    count = (mode == 0) ? $urandom_range(0, total - 1) : total;
                    send_run(fn, total - fn, mode != 1, count);
                    loaded += count;
                    if (count < total) begin
                        break;
                    end
                end
            end
            wait_idle();
        end

        if (tracker.merged_q.size() != 0) begin
            tracker.report($sformatf("%0d merged values never arrived",
                                     tracker.merged_q.size()));
        end
        if (tracker.fail_count == 0) begin
            $display("gap_merge_sorted_arrays test passed");
        end else begin
            $display("gap_merge_sorted_arrays test failed");
        end
        $finish;
    end

endmodule
